/* rtl/core/assert_macros.svh */
// assertion macros used by the deframer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PRBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRBD_ASSERT(label, prop, msg)
`define PRBD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* rtl/core/prbd_pkg.sv */
// types and constants of the pixel readout bitstream deframer
package prbd_pkg;

  localparam int BUFFER_WORDS = 1024;
  localparam int IDX_W        = $clog2(BUFFER_WORDS);
  localparam int HIST_W       = 64;
  localparam int WORD_W       = 16;
  localparam int SCAN_WORDS   = 3;
  localparam int LANES        = SCAN_WORDS * WORD_W;
  localparam int CANDS        = LANES * 4;
  localparam int SEL_W        = $clog2(CANDS);
  localparam int WIN_W        = 36;
  localparam int ROOM_W       = 7;
  localparam int POS_W        = 14;
  localparam int MAX_RECORDS  = 12;
  localparam int CNT_W        = 4;

  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_ROC = 2'd1;
  localparam logic [1:0] KIND_TRL = 2'd2;

  localparam logic [1:0] REG_TBM_HDR = 2'd0;
  localparam logic [1:0] REG_TBM_TRL = 2'd1;
  localparam logic [1:0] REG_ROC_HDR = 2'd2;

  localparam logic [11:0] TBM_HDR_RESET = 12'd2044;
  localparam logic [11:0] TBM_TRL_RESET = 12'd2046;
  localparam logic [9:0]  ROC_HDR_RESET = 10'd510;

  typedef struct packed {
    logic [15:0] low_half;
    logic [15:0] high_half;
    logic        final_word;
  } in_t;

  typedef struct packed {
    logic        channel;
    logic [1:0]  record_kind;
    logic [13:0] bit_position;
    logic [7:0]  event_count;
    logic [1:0]  data_id;
    logic [5:0]  header_payload;
    logic [1:0]  readback_bits;
    logic [5:0]  hit_column;
    logic [8:0]  hit_row;
    logic [7:0]  pulse_height;
    logic [15:0] trailer_payload;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic ht_hit;
    logic roc_hit;
    out_t ht_rec;
    out_t roc_rec;
  } lane_res_t;

  typedef struct packed {
    logic done;
  } merge_stat_t;

endpackage

/* rtl/core/prbd_lane.sv */
// one bit offset of one channel: pattern compare and field extraction
module prbd_lane
  import prbd_pkg::*;
(
  input  logic [WIN_W-1:0]  win,
  input  logic [ROOM_W-1:0] room,
  input  logic [11:0]       tbm_hdr,
  input  logic [11:0]       tbm_trl,
  input  logic [9:0]        roc_hdr,
  output lane_res_t         res
);

  logic       hdr_m;
  logic       trl_m;
  logic [8:0] v9;

  assign hdr_m = (win[35:24] == tbm_hdr);
  assign trl_m = (win[35:24] == tbm_trl);
  assign v9    = (room >= 7'd36) ? win[8:0] : '1;

  always_comb begin
    res = '0;
    res.ht_hit  = hdr_m | trl_m;
    res.roc_hit = (win[35:26] == roc_hdr);
    if (hdr_m) begin
      res.ht_rec.record_kind    = KIND_HDR;
      res.ht_rec.event_count    = (room >= 7'd20) ? win[23:16] : '1;
      res.ht_rec.data_id        = (room >= 7'd22) ? win[15:14] : '1;
      res.ht_rec.header_payload = (room >= 7'd28) ? win[13:8] : '1;
    end else begin
      res.ht_rec.record_kind     = KIND_TRL;
      res.ht_rec.trailer_payload = (room >= 7'd28) ? win[23:8] : '1;
    end
    res.roc_rec.record_kind   = KIND_ROC;
    res.roc_rec.readback_bits = (room >= 7'd12) ? win[25:24] : '1;
    res.roc_rec.hit_column    = (room >= 7'd18) ? win[23:18] : '1;
    res.roc_rec.hit_row       = (room >= 7'd27) ? win[17:9] : '1;
    res.roc_rec.pulse_height  = {v9[8:5], v9[3:0]};
  end

endmodule

/* rtl/core/prbd_merge.sv */
// merges lane matches into stream order and drives the record output register
module prbd_merge
  import prbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pend_valid,
  input  logic [IDX_W-1:0] pend_index,
  input  logic [CANDS-1:0] hit,
  input  out_t             rec [CANDS],
  input  logic             out_ready,
  output logic             out_valid,
  output out_t             out_data,
  output merge_stat_t      stat
);

  logic [CANDS-1:0] taken_r;
  logic [CANDS-1:0] taken_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  out_t             out_data_r;

  logic [CANDS-1:0]   eff;
  logic [CANDS-1:0]   onehot;
  logic [SEL_W-1:0]   sel;
  logic               has;
  logic               last;
  logic               adv;
  logic               emit;
  logic               done;
  logic [1:0]         back_words;
  logic [POS_W-5:0]   wpart;
  out_t               rec_sel;

  assign eff = hit & ~taken_r;

  always_comb begin
    sel = '0;
    for (int i = CANDS - 1; i >= 0; i--) begin
      if (eff[i]) sel = SEL_W'(i);
    end
  end

  assign onehot = CANDS'(1) << sel;
  assign has    = pend_valid & (|eff) & (cnt_r != CNT_W'(MAX_RECORDS));
  assign last   = ((eff & ~onehot) == '0) | (cnt_r == CNT_W'(MAX_RECORDS - 1));
  assign adv    = ~out_valid_r | out_ready;
  assign emit   = has & adv;
  assign done   = pend_valid & (~has | (emit & last));

  // scanned word sits three, two or one words before the newest
  assign back_words = 2'd3 - sel[SEL_W-1:SEL_W-2];
  assign wpart      = (POS_W-4)'(pend_index) - (POS_W-4)'(back_words);

  always_comb begin
    rec_sel              = rec[sel];
    rec_sel.channel      = sel[1];
    rec_sel.bit_position = {wpart, sel[5:2]};
    rec_sel.last_of_run  = last;
  end

  always_comb begin
    taken_nxt = taken_r;
    cnt_nxt   = cnt_r;
    if (done) begin
      taken_nxt = '0;
      cnt_nxt   = '0;
    end else if (emit) begin
      taken_nxt = taken_r | onehot;
      cnt_nxt   = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      taken_r <= taken_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= rec_sel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign stat.done = done;

endmodule

/* rtl/core/pixel_readout_bitstream_deframer.sv */
// Pixel readout bitstream deframer top level. Takes one 32-bit word per
// transfer (16 bits per channel) and scans the word three places back for
// module header, module trailer and chip header patterns at all 16 bit
// offsets of both channels in parallel lanes; a final word also scans the
// two newer pending words. A word that yields no records does not hold the
// input, so such words stream at one per clock. A word with records (at most
// 12) holds the input until the merge stage has sent the last, one record
// per cycle through the output register while out_ready does not stall it.
// Records pass the pending and output registers. No clearing pass after reset.
`include "assert_macros.svh"

module pixel_readout_bitstream_deframer
  import prbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0] tbm_hdr_r;
  logic [11:0] tbm_trl_r;
  logic [9:0]  roc_hdr_r;

  logic [HIST_W-1:0] hist0_r;
  logic [HIST_W-1:0] hist1_r;
  logic [IDX_W-1:0]  wi_r;
  logic [1:0]        held_r;

  logic              pend_valid_r;
  logic [HIST_W-1:0] p_h0_r;
  logic [HIST_W-1:0] p_h1_r;
  logic [IDX_W-1:0]  p_wi_r;
  logic [1:0]        p_held_r;
  logic              p_fin_r;

  logic              in_xfer;
  logic              cfg_wr;
  logic              fin_in;
  logic [HIST_W-1:0] sh0;
  logic [HIST_W-1:0] sh1;
  logic [SCAN_WORDS-1:0] wen;
  logic [HIST_W+WIN_W-1:0] ext0;
  logic [HIST_W+WIN_W-1:0] ext1;
  logic [CANDS-1:0]  hit;
  out_t              rec [CANDS];
  merge_stat_t       stat;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbm_hdr_r <= TBM_HDR_RESET;
      tbm_trl_r <= TBM_TRL_RESET;
      roc_hdr_r <= ROC_HDR_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TBM_HDR: tbm_hdr_r <= pwdata[11:0];
        REG_TBM_TRL: tbm_trl_r <= pwdata[11:0];
        REG_ROC_HDR: roc_hdr_r <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TBM_HDR: prdata = 32'(tbm_hdr_r);
      REG_TBM_TRL: prdata = 32'(tbm_trl_r);
      REG_ROC_HDR: prdata = 32'(roc_hdr_r);
      default:     prdata = '0;
    endcase
  end

  // input transfer and stream history
  assign in_ready = ~pend_valid_r | stat.done;
  assign in_xfer  = in_valid & in_ready;
  assign fin_in   = in_data.final_word | (wi_r >= IDX_W'(BUFFER_WORDS - 1));
  assign sh0      = {hist0_r[HIST_W-WORD_W-1:0], in_data.low_half};
  assign sh1      = {hist1_r[HIST_W-WORD_W-1:0], in_data.high_half};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist0_r      <= '0;
      hist1_r      <= '0;
      wi_r         <= '0;
      held_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        pend_valid_r <= 1'b1;
        if (fin_in) begin
          hist0_r <= '0;
          hist1_r <= '0;
          wi_r    <= '0;
          held_r  <= '0;
        end else begin
          hist0_r <= sh0;
          hist1_r <= sh1;
          wi_r    <= wi_r + 1'b1;
          if (held_r != 2'd3) held_r <= held_r + 2'd1;
        end
      end else if (stat.done) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p_h0_r   <= sh0;
      p_h1_r   <= sh1;
      p_wi_r   <= wi_r;
      p_held_r <= held_r;
      p_fin_r  <= fin_in;
    end
  end

  // lanes over the three scanned words
  assign wen[0] = (p_held_r == 2'd3);
  assign wen[1] = p_fin_r & (p_held_r >= 2'd2);
  assign wen[2] = p_fin_r & (p_held_r >= 2'd1);
  assign ext0   = {p_h0_r, {WIN_W{1'b0}}};
  assign ext1   = {p_h1_r, {WIN_W{1'b0}}};

  for (genvar r = 0; r < LANES; r++) begin : g_lane
    lane_res_t res0;
    lane_res_t res1;

    prbd_lane u_lane0 (
      .win     (ext0[HIST_W+WIN_W-1-r -: WIN_W]),
      .room    (ROOM_W'(HIST_W - r)),
      .tbm_hdr (tbm_hdr_r),
      .tbm_trl (tbm_trl_r),
      .roc_hdr (roc_hdr_r),
      .res     (res0)
    );

    prbd_lane u_lane1 (
      .win     (ext1[HIST_W+WIN_W-1-r -: WIN_W]),
      .room    (ROOM_W'(HIST_W - r)),
      .tbm_hdr (tbm_hdr_r),
      .tbm_trl (tbm_trl_r),
      .roc_hdr (roc_hdr_r),
      .res     (res1)
    );

    assign hit[r*4]     = res0.ht_hit & wen[r/WORD_W];
    assign hit[r*4 + 1] = res0.roc_hit & wen[r/WORD_W];
    assign hit[r*4 + 2] = res1.ht_hit & wen[r/WORD_W];
    assign hit[r*4 + 3] = res1.roc_hit & wen[r/WORD_W];
    assign rec[r*4]     = res0.ht_rec;
    assign rec[r*4 + 1] = res0.roc_rec;
    assign rec[r*4 + 2] = res1.ht_rec;
    assign rec[r*4 + 3] = res1.roc_rec;
  end

  prbd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .pend_valid (pend_valid_r),
    .pend_index (p_wi_r),
    .hit        (hit),
    .rec        (rec),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .stat       (stat)
  );

  `PRBD_ASSERT(a_held_tracks_index, (held_r != 2'd3) |-> (wi_r == IDX_W'(held_r)), "held count out of step with word index")
  `PRBD_ASSERT(a_final_restarts, (in_xfer && fin_in) |=> (wi_r == '0 && held_r == 2'd0 && hist0_r == '0), "final word did not restart the buffer")
  `PRBD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!out_valid && !pend_valid_r), "activity right after reset")

endmodule

/* bench/pixel_readout_bitstream_deframer_test.sv */
// testbench of the pixel readout bitstream deframer: stream scan prediction and record checks
module pixel_readout_bitstream_deframer_test;
  import prbd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pixel_readout_bitstream_deframer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [11:0] hdr_pat;
  logic [11:0] trl_pat;
  logic [9:0]  roc_pat;
  logic [63:0] stream_hist [2];
  int unsigned word_idx;
  int unsigned held_words;

  in_t  word_queue [$];
  out_t record_queue [$];
  int   error_count;
  int   word_count;
  int   record_count;
  int   burst_left;
  int   gap_left;
  int   stall_phase;
  bit   drive_enable;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch %s: got %0h want %0h (record %0d)", what, got, want, record_count);
  endtask

  function automatic logic [63:0] grab(input logic [63:0] h, input int r, input int len);
    logic [63:0] mask;
    mask = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
    if (r + len > 64) return mask;
    return (h >> (64 - r - len)) & mask;
  endfunction

  task automatic scan_pending(input int d, inout int n, inout out_t recs [$]);
    int base;
    logic [63:0] h;
    logic [63:0] w12;
    logic [63:0] w10;
    logic [63:0] v9;
    out_t rec;
    base = (3 - d) * 16;
    for (int k = 0; k < 16; k++) begin
      for (int ch = 0; ch < 2; ch++) begin
        h = stream_hist[ch];
        w12 = grab(h, base + k, 12);
        w10 = grab(h, base + k, 10);
        if (w12 == hdr_pat || w12 == trl_pat) begin
          rec = '0;
          rec.channel = ch[0];
          rec.bit_position = 14'((word_idx - d) * 16 + k);
          if (w12 == hdr_pat) begin
            rec.record_kind = KIND_HDR;
            rec.event_count = 8'(grab(h, base + k + 12, 8));
            rec.data_id = 2'(grab(h, base + k + 20, 2));
            rec.header_payload = 6'(grab(h, base + k + 22, 6));
          end else begin
            rec.record_kind = KIND_TRL;
            rec.trailer_payload = 16'(grab(h, base + k + 12, 16));
          end
          if (n < MAX_RECORDS) begin
            recs.insert(recs.size(), rec);
            n++;
          end
        end
        if (w10 == roc_pat) begin
          v9 = grab(h, base + k + 27, 9);
          rec = '0;
          rec.channel = ch[0];
          rec.record_kind = KIND_ROC;
          rec.bit_position = 14'((word_idx - d) * 16 + k);
          rec.readback_bits = 2'(grab(h, base + k + 10, 2));
          rec.hit_column = 6'(grab(h, base + k + 12, 6));
          rec.hit_row = 9'(grab(h, base + k + 18, 9));
          rec.pulse_height = {v9[8:5], v9[3:0]};
          if (n < MAX_RECORDS) begin
            recs.insert(recs.size(), rec);
            n++;
          end
        end
      end
    end
  endtask

  task automatic predict_records(input in_t w);
    int n;
    bit fin;
    out_t recs [$];
    n = 0;
    fin = w.final_word || (word_idx >= BUFFER_WORDS - 1);
    stream_hist[0] = {stream_hist[0][47:0], w.low_half};
    stream_hist[1] = {stream_hist[1][47:0], w.high_half};
    if (held_words >= 3) scan_pending(3, n, recs);
    if (fin) begin
      if (held_words >= 2) scan_pending(2, n, recs);
      if (held_words >= 1) scan_pending(1, n, recs);
    end
    if (n > 0) recs[n-1].last_of_run = 1'b1;
    foreach (recs[i]) record_queue.insert(record_queue.size(), recs[i]);
    if (fin) begin
      stream_hist[0] = '0;
      stream_hist[1] = '0;
      word_idx = 0;
      held_words = 0;
    end else begin
      word_idx++;
      if (held_words < 3) held_words++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_records(in_data);
        word_count++;
      end
      if (!in_valid || in_ready) begin
        if (drive_enable && word_queue.size() > 0 && gap_left == 0) begin
          in_valid <= 1'b1;
          in_data <= word_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      out_ready <= (stall_phase % 64 < 24) ? 1'b1 : ($urandom_range(0, 2) != 0);
      if (out_valid && out_ready) begin
        record_count++;
        if (record_queue.size() == 0) begin
          report_mismatch("unexpected record", out_data.bit_position, 0);
        end else begin
          out_t want;
          want = record_queue.pop_front();
          if (out_data.channel != want.channel)
            report_mismatch("channel", out_data.channel, want.channel);
          if (out_data.record_kind != want.record_kind)
            report_mismatch("record_kind", out_data.record_kind, want.record_kind);
          if (out_data.bit_position != want.bit_position)
            report_mismatch("bit_position", out_data.bit_position, want.bit_position);
          if (out_data.event_count != want.event_count)
            report_mismatch("event_count", out_data.event_count, want.event_count);
          if (out_data.data_id != want.data_id)
            report_mismatch("data_id", out_data.data_id, want.data_id);
          if (out_data.header_payload != want.header_payload)
            report_mismatch("header_payload", out_data.header_payload, want.header_payload);
          if (out_data.readback_bits != want.readback_bits)
            report_mismatch("readback_bits", out_data.readback_bits, want.readback_bits);
          if (out_data.hit_column != want.hit_column)
            report_mismatch("hit_column", out_data.hit_column, want.hit_column);
          if (out_data.hit_row != want.hit_row)
            report_mismatch("hit_row", out_data.hit_row, want.hit_row);
          if (out_data.pulse_height != want.pulse_height)
            report_mismatch("pulse_height", out_data.pulse_height, want.pulse_height);
          if (out_data.trailer_payload != want.trailer_payload)
            report_mismatch("trailer_payload", out_data.trailer_payload,
                            want.trailer_payload);
          if (out_data.last_of_run != want.last_of_run)
            report_mismatch("last_of_run", out_data.last_of_run, want.last_of_run);
        end
      end
    end
  end

  task automatic write_pattern(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TBM_HDR: hdr_pat = value[11:0];
      REG_TBM_TRL: trl_pat = value[11:0];
      default:     roc_pat = value[9:0];
    endcase
  endtask

  // wait until all words are in and every record is out
  task automatic drain_block();
    int spins;
    spins = 0;
    while ((word_queue.size() > 0 || in_valid || record_queue.size() > 0) && spins < 400000) begin
      @(posedge clk);
      spins++;
    end
    repeat (20) @(posedge clk);
  endtask

  function automatic in_t make_word(input logic [15:0] lo, input logic [15:0] hi,
                                    input bit fin);
    in_t w;
    w.low_half = lo;
    w.high_half = hi;
    w.final_word = fin;
    return w;
  endfunction

  // place one to four random patterns at random offsets of a short framed buffer
  task automatic queue_framed_buffer(input int words);
    logic [15:0] lo [];
    logic [15:0] hi [];
    int nbits;
    int off;
    int kind;
    int ch;
    logic [11:0] pat;
    int plen;
    lo = new[words];
    hi = new[words];
    for (int i = 0; i < words; i++) begin
      lo[i] = 16'($urandom);
      hi[i] = 16'($urandom);
    end
    nbits = words * 16;
    for (int m = 0; m < $urandom_range(1, 4); m++) begin
      kind = $urandom_range(0, 2);
      ch = $urandom_range(0, 1);
      pat = (kind == 0) ? hdr_pat : (kind == 1) ? trl_pat : {2'b00, roc_pat};
      plen = (kind == 2) ? 10 : 12;
      off = $urandom_range(0, nbits - plen);
      for (int b = 0; b < plen; b++) begin
        int p;
        p = off + b;
        if (ch == 0) lo[p / 16][15 - p % 16] = pat[plen - 1 - b];
        else hi[p / 16][15 - p % 16] = pat[plen - 1 - b];
      end
    end
    for (int i = 0; i < words; i++)
      word_queue.insert(word_queue.size(), make_word(lo[i], hi[i], i == words - 1));
  endtask

  initial begin
    logic [31:0] rd;
    error_count = 0;
    word_count = 0;
    record_count = 0;
    drive_enable = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hdr_pat = TBM_HDR_RESET;
    trl_pat = TBM_TRL_RESET;
    roc_pat = ROC_HDR_RESET;
    stream_hist[0] = '0;
    stream_hist[1] = '0;
    word_idx = 0;
    held_words = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset patterns, extremes, match at buffer end, both channels at one offset
    word_queue.insert(word_queue.size(), make_word(16'h0000, 16'h0000, 1'b0));
    word_queue.insert(word_queue.size(), make_word(16'hFFFF, 16'hFFFF, 1'b0));
    word_queue.insert(word_queue.size(), make_word(16'h7FCA, 16'h7FEB, 1'b0));
    word_queue.insert(word_queue.size(), make_word(16'h5A5A, 16'hA5A5, 1'b0));
    word_queue.insert(word_queue.size(), make_word(16'h7FC0, 16'h7FC0, 1'b0));
    word_queue.insert(word_queue.size(), make_word(16'h1234, 16'h8001, 1'b0));
    word_queue.insert(word_queue.size(), make_word(16'h007F, 16'hC000, 1'b1));
    word_queue.insert(word_queue.size(), make_word(16'h7FE0, 16'h7FE0, 1'b1));
    word_queue.insert(word_queue.size(), make_word(16'h0000, 16'h0000, 1'b0));
    word_queue.insert(word_queue.size(), make_word(16'h07FC, 16'h03FE, 1'b1));
    word_queue.insert(word_queue.size(), make_word(16'hFFFF, 16'h0000, 1'b0));
    word_queue.insert(word_queue.size(), make_word(16'hFFFF, 16'hFFFF, 1'b0));
    word_queue.insert(word_queue.size(), make_word(16'h0000, 16'hFFFF, 1'b0));
    word_queue.insert(word_queue.size(), make_word(16'hFFFF, 16'h0000, 1'b1));
    drive_enable = 1'b1;
    drain_block();

    // equal header and trailer patterns, zero chip pattern (many matches)
    drive_enable = 1'b0;
    write_pattern(REG_TBM_HDR, 32'h0000_0000);
    write_pattern(REG_TBM_TRL, 32'h0000_0000);
    write_pattern(REG_ROC_HDR, 32'h0000_0000);
    for (int i = 0; i < 6; i++)
      word_queue.insert(word_queue.size(), make_word('0, '0, i == 5));
    drive_enable = 1'b1;
    drain_block();

    // all-ones header and chip patterns: fields past the end read as ones
    drive_enable = 1'b0;
    write_pattern(REG_TBM_HDR, 32'h0000_0FFF);
    write_pattern(REG_TBM_TRL, 32'hFFFF_F5A5);
    write_pattern(REG_ROC_HDR, 32'h0000_03FF);
    for (int i = 0; i < 5; i++)
      word_queue.insert(word_queue.size(), make_word('1, '1, i == 4));
    drive_enable = 1'b1;
    drain_block();

    // random and reset pattern phases with framed buffers and noise
    for (int ph = 0; ph < 4; ph++) begin
      drive_enable = 1'b0;
      if (ph == 3) begin
        write_pattern(REG_TBM_HDR, 32'(TBM_HDR_RESET));
        write_pattern(REG_TBM_TRL, 32'(TBM_TRL_RESET));
        write_pattern(REG_ROC_HDR, 32'(ROC_HDR_RESET));
      end else begin
        write_pattern(REG_TBM_HDR, $urandom);
        write_pattern(REG_TBM_TRL, $urandom);
        write_pattern(REG_ROC_HDR, $urandom);
      end
      for (int b = 0; b < 14; b++) begin
        if ($urandom_range(0, 4) == 0) begin
          for (int i = 0; i < $urandom_range(1, 6); i++)
            word_queue.insert(word_queue.size(),
                              make_word(16'($urandom), 16'($urandom),
                                        $urandom_range(0, 3) == 0));
        end else begin
          queue_framed_buffer($urandom_range(1, 8));
        end
      end
      drive_enable = 1'b1;
      drain_block();
    end

    rd = prdata;
    if (record_queue.size() > 0 || word_queue.size() > 0 || in_valid) begin
      $display("Test completed with failures");
      $finish;
    end
    $display("covered %0d words and %0d records over several pattern settings",
             word_count, record_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/prbd_pkg.sv
rtl/core/prbd_lane.sv
rtl/core/prbd_merge.sv
rtl/core/pixel_readout_bitstream_deframer.sv
bench/pixel_readout_bitstream_deframer_test.sv
